### hdl/greedy_row_packer_top_assert.svh
// assertion macros shared by the row packer top level
`ifndef GREEDY_ROW_PACKER_TOP_ASSERT_SVH
`define GREEDY_ROW_PACKER_TOP_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define GRP_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("row packer check failed");

// condition holds in the cycle after the trigger
`define GRP_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("row packer check failed");

`endif

### hdl/grp_pkg.sv
// ----------------------------------------------------------------------------
// grp_pkg
// Shared widths, register codes and types of the greedy row packer.
// ----------------------------------------------------------------------------
package grp_pkg;

    localparam int GRP_MAX_ROWS = 16;
    localparam int ROW_W        = 6;
    localparam int WIDTH_W      = 16;
    localparam int GW_W         = 12;
    localparam int SPACE_W      = 8;
    localparam int NROWS_W      = 7;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 8;

    localparam logic [WIDTH_W-1:0] WIDTH_MAX = {WIDTH_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS = 8'd0,
        CFG_SPACING  = 8'd1
    } t_cfg_idx;

    // requests from the scan sequencer to the row width memory
    typedef struct packed {
        logic               clear;
        logic [SPACE_W-1:0] base;
        logic               rd_en;
        logic [ROW_W-1:0]   rd_addr;
        logic               wr_en;
        logic [ROW_W-1:0]   wr_addr;
        logic [WIDTH_W-1:0] wr_data;
    } t_mem_req;

endpackage

### hdl/grp_ifs.sv
// ----------------------------------------------------------------------------
// grp_ifs
// Handshake channels of the row packer: glyph in, placement out, config.
// ----------------------------------------------------------------------------
interface grp_glyph_if;
    logic                       valid;
    logic                       ready;
    logic [grp_pkg::GW_W-1:0]   glyph_width;
    logic                       first_glyph;
    logic                       last_glyph;

    modport source (output valid, glyph_width, first_glyph, last_glyph, input ready);
    modport sink   (input valid, glyph_width, first_glyph, last_glyph, output ready);
endinterface

interface grp_place_if;
    logic                         valid;
    logic                         ready;
    logic [grp_pkg::ROW_W-1:0]    chosen_row;
    logic [grp_pkg::WIDTH_W-1:0]  x_offset;
    logic [grp_pkg::WIDTH_W-1:0]  max_width;
    logic                         set_done;

    modport source (output valid, chosen_row, x_offset, max_width, set_done, input ready);
    modport sink   (input valid, chosen_row, x_offset, max_width, set_done, output ready);
endinterface

interface grp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [grp_pkg::CFG_IDX_W-1:0]   index;
    logic [grp_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/grp_row_mem.sv
// ----------------------------------------------------------------------------
// grp_row_mem
// Row width memory: one read and one write port, registered read data.
// A per-row valid bit lets a set start clear every row to the base at once.
// ----------------------------------------------------------------------------
module grp_row_mem #(
    parameter int MAX_ROWS = grp_pkg::GRP_MAX_ROWS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  grp_pkg::t_mem_req            i_req,
    output logic [grp_pkg::WIDTH_W-1:0]  o_rd_data
);
    import grp_pkg::*;

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [WIDTH_W-1:0]  r_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_valid;
    logic [SPACE_W-1:0]  r_base;
    logic [WIDTH_W-1:0]  r_rd_data;

    logic [AW-1:0] rd_idx;
    logic [AW-1:0] wr_idx;

    assign rd_idx    = i_req.rd_addr[AW-1:0];
    assign wr_idx    = i_req.wr_addr[AW-1:0];
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[wr_idx] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            // rows not written since the set start read as the base
            r_rd_data <= r_valid[rd_idx] ? r_mem[rd_idx]
                                         : {{(WIDTH_W-SPACE_W){1'b0}}, r_base};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_base  <= '0;
        end else if (i_req.clear) begin
            r_valid <= '0;
            r_base  <= i_req.base;
        end else if (i_req.wr_en) begin
            r_valid[wr_idx] <= 1'b1;
        end
    end

endmodule

### hdl/grp_scanner.sv
// ----------------------------------------------------------------------------
// grp_scanner
// Scan sequencer: reads the active rows one a cycle, keeps the narrowest,
// writes the grown row back and registers the placement beat.
// ----------------------------------------------------------------------------
module grp_scanner #(
    parameter int MAX_ROWS = grp_pkg::GRP_MAX_ROWS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    grp_glyph_if.sink                    i_glyph,
    grp_place_if.source                  o_place,
    input  logic [grp_pkg::NROWS_W-1:0]  i_num_rows,
    input  logic [grp_pkg::SPACE_W-1:0]  i_spacing,
    output grp_pkg::t_mem_req            o_mem_req,
    input  logic [grp_pkg::WIDTH_W-1:0]  i_rd_data
);
    import grp_pkg::*;

    localparam logic [NROWS_W-1:0] MAXN = NROWS_W'(MAX_ROWS);
    localparam int SUM_W = WIDTH_W + 2;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_UPDATE} t_state;

    t_state             r_state;
    logic [ROW_W-1:0]   r_idx;
    logic [ROW_W-1:0]   r_last_idx;
    logic               r_cmp_vld;
    logic [ROW_W-1:0]   r_cmp_idx;
    logic [ROW_W-1:0]   r_best_idx;
    logic [WIDTH_W-1:0] r_best_val;
    logic [GW_W-1:0]    r_gw;
    logic               r_last;
    logic [WIDTH_W-1:0] r_widest;
    logic               r_out_vld;
    logic [ROW_W-1:0]   r_out_row;
    logic [WIDTH_W-1:0] r_out_x;
    logic [WIDTH_W-1:0] r_out_max;
    logic               r_out_done;

    logic [NROWS_W-1:0] n_active;
    logic [NROWS_W-1:0] n_last_idx;
    logic [SUM_W-1:0]   n_sum;
    logic [WIDTH_W-1:0] n_after;
    logic [WIDTH_W-1:0] n_widest;
    logic               accept;
    logic               out_free;
    logic               commit;
    logic               take_best;

    assign n_active   = (i_num_rows == '0) ? NROWS_W'(1)
                      : (i_num_rows > MAXN) ? MAXN : i_num_rows;
    assign n_last_idx = n_active - NROWS_W'(1);

    assign accept   = i_glyph.valid && i_glyph.ready;
    assign out_free = !r_out_vld || o_place.ready;
    assign commit   = (r_state == S_UPDATE) && out_free;

    assign n_sum    = SUM_W'(r_best_val) + SUM_W'(r_gw) + SUM_W'(i_spacing);
    assign n_after  = (n_sum > SUM_W'(WIDTH_MAX)) ? WIDTH_MAX : n_sum[WIDTH_W-1:0];
    assign n_widest = (n_after > r_widest) ? n_after : r_widest;

    // ties keep the lower row
    assign take_best = r_cmp_vld && ((r_cmp_idx == '0) || (i_rd_data < r_best_val));

    assign i_glyph.ready = (r_state == S_IDLE);

    assign o_place.valid      = r_out_vld;
    assign o_place.chosen_row = r_out_row;
    assign o_place.x_offset   = r_out_x;
    assign o_place.max_width  = r_out_max;
    assign o_place.set_done   = r_out_done;

    always_comb begin
        o_mem_req         = '0;
        o_mem_req.clear   = accept && i_glyph.first_glyph;
        o_mem_req.base    = i_spacing;
        o_mem_req.rd_en   = (r_state == S_SCAN);
        o_mem_req.rd_addr = r_idx;
        o_mem_req.wr_en   = commit;
        o_mem_req.wr_addr = r_best_idx;
        o_mem_req.wr_data = n_after;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_widest  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_cmp_vld <= (r_state == S_SCAN);
            r_cmp_idx <= r_idx;
            if (take_best) begin
                r_best_idx <= r_cmp_idx;
                r_best_val <= i_rd_data;
            end
            if (commit) begin
                r_out_vld <= 1'b1;
            end else if (o_place.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_gw       <= i_glyph.glyph_width;
                        r_last     <= i_glyph.last_glyph;
                        r_last_idx <= n_last_idx[ROW_W-1:0];
                        r_idx      <= '0;
                        if (i_glyph.first_glyph) begin
                            r_widest <= {{(WIDTH_W-SPACE_W){1'b0}}, i_spacing};
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + ROW_W'(1);
                    if (r_idx == r_last_idx) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (out_free) begin
                        r_widest   <= n_widest;
                        r_out_row  <= r_best_idx;
                        r_out_x    <= r_best_val;
                        r_out_max  <= n_widest;
                        r_out_done <= r_last;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/greedy_row_packer_top.sv
// ----------------------------------------------------------------------------
// greedy_row_packer_top
// Places each glyph in the least filled atlas row, lowest row on a tie.
//
// i_glyph carries one glyph width per beat; first_glyph starts a new set
// with every row at the spacing value, last_glyph is echoed as set_done.
// o_place returns one beat per glyph: row, x offset and widest row so far.
// i_cfg writes num_rows (index 0) and spacing (index 1), idle time only;
// it is always ready and does not itself enforce the idle time rule.
// A glyph's result is registered by the update state after its accept: the
// row width memory has one read port, so the scan reads the active rows one
// a cycle, then a drain state waits for the last read and the update state
// writes the grown row back. The idle state then takes the next glyph.
// One glyph is in flight at a time; the next is taken as soon as the
// result is registered, even while o_place is stalled. A stalled result
// holds the write-back until the output register frees up.
// Reset gives num_rows 1, spacing 0 and all row widths zero.
// ----------------------------------------------------------------------------
module greedy_row_packer_top #(
    parameter int MAX_ROWS = grp_pkg::GRP_MAX_ROWS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    grp_glyph_if.sink     i_glyph,
    grp_place_if.source   o_place,
    grp_cfg_if.sink       i_cfg
);
    import grp_pkg::*;

`include "greedy_row_packer_top_assert.svh"

    logic [NROWS_W-1:0] r_num_rows;
    logic [SPACE_W-1:0] r_spacing;
    t_mem_req           mem_req;
    logic [WIDTH_W-1:0] rd_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= NROWS_W'(1);
            r_spacing  <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.index == CFG_NUM_ROWS) begin
                r_num_rows <= i_cfg.data[NROWS_W-1:0];
            end else if (i_cfg.index == CFG_SPACING) begin
                r_spacing <= i_cfg.data[SPACE_W-1:0];
            end
        end
    end

    grp_scanner #(
        .MAX_ROWS (MAX_ROWS)
    ) u_scanner (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_glyph    (i_glyph),
        .o_place    (o_place),
        .i_num_rows (r_num_rows),
        .i_spacing  (r_spacing),
        .o_mem_req  (mem_req),
        .i_rd_data  (rd_data)
    );

    grp_row_mem #(
        .MAX_ROWS (MAX_ROWS)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // one glyph in flight: the scan holds off the next beat
    `GRP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_glyph.valid && i_glyph.ready, !i_glyph.ready)
    // a read and a write never hit the memory in the same cycle
    `GRP_ASSERT_SAME(a_no_rw_overlap, i_clk, i_rst_n, mem_req.wr_en, !mem_req.rd_en && !mem_req.clear)
    `GRP_ASSERT_SAME(a_row_in_range, i_clk, i_rst_n, o_place.valid, {1'b0, o_place.chosen_row} < NROWS_W'(MAX_ROWS))
    `GRP_ASSERT_SAME(a_max_covers_x, i_clk, i_rst_n, o_place.valid, o_place.max_width >= o_place.x_offset)

endmodule
